FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions sharing the block clock and reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

FILE: rtl/bbd_pkg.sv
// ---------------------------------------------------------------------------
// bbd_pkg
// shared constants and types of the bilinear bayer demosaic block
// ---------------------------------------------------------------------------
package bbd_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int MAX_WIDTH  = 8192;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 14;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_EXT_W  = HEIGHT_W + 1;
    localparam int PEND_W     = 14;
    localparam int CHAN_W     = PIXEL_BITS + 2;

    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 56;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(2);
    localparam logic [PEND_W-1:0]   PEND_ONE   = PEND_W'(1);

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [CHAN_W-1:0]     chan_t;

    typedef enum logic [1:0] {
        EMIT_NORMAL,
        EMIT_SHIFTED,
        EMIT_HELD
    } emit_mode_t;

    typedef struct packed {
        emit_mode_t mode;
        logic       row_odd;
        logic       col_odd;
        logic       up;
        logic       down;
        logic       left;
        logic       right;
        logic       row_end;
        logic       frame_end;
    } emit_meta_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
        logic  frame_end;
    } result_t;

endpackage

FILE: rtl/bayer_bilinear_demosaic_top.sv
// ---------------------------------------------------------------------------
// bayer_bilinear_demosaic_top
// full-resolution bilinear demosaic of a gbrg raw stream with two line stores
// ---------------------------------------------------------------------------
// channel  | ports        | payload
// input    | s_t*         | tdata raw sample, tuser 0 pixel / 1 drain
// result   | m_t*         | tdata red green blue, tlast row end, tuser frame end
// config   | apb          | 0x0 frame width, 0x4 frame height
//
// one request per cycle if s_tready is high; results are registered, then queued
// line stores are read on request, written back the next cycle, with forwarding
// reset is synchronous and needs no clearing pass
// s_tready drops when the 4-entry result queue plus in-flight results is full
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bayer_bilinear_demosaic_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bbd_pkg::S_DATA_W-1:0]   s_tdata,   // raw_pixel
    input  logic                           s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bbd_pkg::M_DATA_W-1:0]   m_tdata,   // red_value, green_value, blue_value
    output logic                           m_tlast,
    output logic                           m_tuser,   // frame_end
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import bbd_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]  width_raw_reg, width_raw_next, width_eff_reg, width_eff_next;
    logic [HEIGHT_W-1:0] height_raw_reg, height_raw_next, height_eff_reg, height_eff_next;
    logic                cfg_wr;
    logic                cfg_idx;

    // position and drain state
    logic [ADDR_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [HEIGHT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;

    // request stage
    logic                s_accept;
    logic                a_adv;
    logic                a_held;
    logic [HEIGHT_W-1:0] a_row;
    logic [ADDR_W-1:0]   a_col;
    pixel_t              a_pix;
    logic                a_emit;
    emit_meta_t          a_meta;
    logic [WIDTH_W-1:0]  w_plus1;
    logic [WIDTH_W-1:0]  col_inc;
    logic [ROW_EXT_W-1:0] row_inc;
    logic [ROW_EXT_W-1:0] h_ext;
    logic [ROW_EXT_W-1:0] er_p1;
    logic [ROW_EXT_W-1:0] er;
    logic [ADDR_W-1:0]   ec;
    logic [ADDR_W-1:0]   w_last;
    logic [WIDTH_W-1:0]  ec_p1;

    // line store stage
    logic                b_adv_reg, b_emit_reg, fwd_hit_reg, fwd_hit_next;
    emit_meta_t          b_meta_reg;
    logic [ADDR_W-1:0]   b_idx_reg;
    pixel_t              b_pix_reg;
    pixel_t              fwd_up_reg, fwd_mid_reg;
    pixel_t              up_rd, mid_rd, up_val, mid_val;
    pixel_t [2:0][2:0]   win_reg, win_next;

    // result stage
    logic                c_emit_reg;
    emit_meta_t          c_meta_reg;
    pixel_t [2:0][2:0]   nb;
    chan_t               pass_v, vs, hs, ds, vs2, hs2, hv;
    logic                both_ud, both_lr, all_in;
    result_t             c_result;

    // result queue
    result_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FIFO_CNT_W-1:0]   occupancy;
    logic                    push, pop;
    result_t                 head;

    // ------------------------------------------------------------------
    // apb registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[2];

    always_comb begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  width_raw_next  = pwdata[WIDTH_W-1:0];
                REG_HEIGHT: height_raw_next = pwdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
        if (width_raw_next < WIDTH_MIN) begin
            width_eff_next = WIDTH_MIN;
        end else if (width_raw_next > WIDTH_MAX) begin
            width_eff_next = WIDTH_MAX;
        end else begin
            width_eff_next = width_raw_next;
        end
        height_eff_next = (height_raw_next < HEIGHT_MIN) ? HEIGHT_MIN : height_raw_next;
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_raw_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_raw_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= WIDTH_MAX;
            width_eff_reg  <= WIDTH_MAX;
            height_raw_reg <= HEIGHT_MIN;
            height_eff_reg <= HEIGHT_MIN;
        end else begin
            width_raw_reg  <= width_raw_next;
            width_eff_reg  <= width_eff_next;
            height_raw_reg <= height_raw_next;
            height_eff_reg <= height_eff_next;
        end
    end

    // ------------------------------------------------------------------
    // request stage: counters, line store address, emit decision
    // ------------------------------------------------------------------
    assign s_accept = s_tvalid & s_tready;
    assign w_plus1  = width_eff_reg + WIDTH_W'(1);
    assign col_inc  = WIDTH_W'(col_cnt_reg) + WIDTH_W'(1);
    assign row_inc  = ROW_EXT_W'(row_cnt_reg) + ROW_EXT_W'(1);
    assign h_ext    = ROW_EXT_W'(height_eff_reg);
    assign w_last   = ADDR_W'(width_eff_reg - WIDTH_W'(1));

    always_comb begin
        a_adv        = 1'b0;
        a_held       = 1'b0;
        a_row        = row_cnt_reg;
        a_col        = col_cnt_reg;
        a_pix        = s_tdata[PIXEL_BITS-1:0];
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        pend_next    = pend_reg;
        if (s_tuser == OP_PIXEL) begin
            a_adv     = 1'b1;
            pend_next = '0;
            if (col_inc >= width_eff_reg) begin
                col_cnt_next = '0;
                if (row_inc >= h_ext) begin
                    row_cnt_next = '0;
                    pend_next    = w_plus1;
                end else begin
                    row_cnt_next = row_inc[HEIGHT_W-1:0];
                end
            end else begin
                col_cnt_next = col_inc[ADDR_W-1:0];
            end
        end else begin
            a_pix = '0;
            a_row = height_eff_reg;
            if (pend_reg == PEND_ONE) begin
                a_held    = 1'b1;
                pend_next = '0;
            end else if (pend_reg != '0) begin
                a_adv     = 1'b1;
                pend_next = pend_reg - PEND_W'(1);
                a_col     = (pend_reg >= w_plus1) ? '0 : ADDR_W'(w_plus1 - pend_reg);
            end
        end
    end

    always_comb begin
        a_emit      = 1'b0;
        a_meta.mode = EMIT_NORMAL;
        er_p1       = '0;
        ec          = '0;
        if (a_held) begin
            a_emit      = 1'b1;
            a_meta.mode = EMIT_HELD;
            er_p1       = h_ext;
            ec          = w_last;
        end else if (a_adv) begin
            if (a_col == '0 && a_row >= HEIGHT_W'(2)) begin
                a_emit      = 1'b1;
                a_meta.mode = EMIT_SHIFTED;
                er_p1       = ROW_EXT_W'(a_row) - ROW_EXT_W'(1);
                ec          = w_last;
            end else if (a_col != '0 && a_row != '0) begin
                a_emit      = 1'b1;
                a_meta.mode = EMIT_NORMAL;
                er_p1       = ROW_EXT_W'(a_row);
                ec          = a_col - ADDR_W'(1);
            end
        end
        er               = er_p1 - ROW_EXT_W'(1);
        ec_p1            = WIDTH_W'(ec) + WIDTH_W'(1);
        a_meta.row_odd   = er[0];
        a_meta.col_odd   = ec[0];
        a_meta.up        = (er != '0);
        a_meta.down      = (er_p1 < h_ext);
        a_meta.left      = (ec != '0);
        a_meta.right     = (ec_p1 < width_eff_reg);
        a_meta.row_end   = (ec_p1 == width_eff_reg);
        a_meta.frame_end = (ec_p1 == width_eff_reg) && (er_p1 == h_ext);
    end

    assign fwd_hit_next = s_accept & a_adv & b_adv_reg & (b_idx_reg == a_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pend_reg    <= '0;
            b_adv_reg   <= 1'b0;
            b_emit_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
            c_emit_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                pend_reg    <= pend_next;
            end
            b_adv_reg   <= s_accept & a_adv;
            b_emit_reg  <= s_accept & a_emit;
            fwd_hit_reg <= fwd_hit_next;
            c_emit_reg  <= b_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_meta_reg  <= a_meta;
        b_idx_reg   <= a_col;
        b_pix_reg   <= a_pix;
        fwd_up_reg  <= mid_val;
        fwd_mid_reg <= b_pix_reg;
        c_meta_reg  <= b_meta_reg;
    end

    // ------------------------------------------------------------------
    // line stores: read on request, write back in the next cycle, not later
    // ------------------------------------------------------------------
    bbd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (b_adv_reg),
        .wr_addr (b_idx_reg),
        .wr_data (mid_val),
        .rd_en   (s_accept & a_adv),
        .rd_addr (a_col),
        .rd_data (up_rd)
    );

    bbd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .aclk    (aclk),
        .wr_en   (b_adv_reg),
        .wr_addr (b_idx_reg),
        .wr_data (b_pix_reg),
        .rd_en   (s_accept & a_adv),
        .rd_addr (a_col),
        .rd_data (mid_rd)
    );

    // back-to-back requests on one column see the write still in flight
    assign up_val  = fwd_hit_reg ? fwd_up_reg  : up_rd;
    assign mid_val = fwd_hit_reg ? fwd_mid_reg : mid_rd;

    always_comb begin
        win_next = win_reg;
        if (b_adv_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = up_val;
            win_next[1][2] = mid_val;
            win_next[2][2] = b_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // result stage: interpolation from the window
    // ------------------------------------------------------------------
    always_comb begin
        nb = win_reg;
        case (c_meta_reg.mode)
            EMIT_NORMAL: nb = win_reg;
            EMIT_SHIFTED: begin
                for (int i = 0; i < 3; i++) begin
                    nb[i][0] = win_reg[i][0];
                    nb[i][1] = win_reg[i][1];
                    nb[i][2] = '0;
                end
            end
            EMIT_HELD: begin
                for (int i = 0; i < 3; i++) begin
                    nb[i][0] = win_reg[i][1];
                    nb[i][1] = win_reg[i][2];
                    nb[i][2] = '0;
                end
            end
            default: nb = win_reg;
        endcase
    end

    assign pass_v  = {nb[1][1], 2'b00};
    assign vs      = CHAN_W'(nb[0][1]) + CHAN_W'(nb[2][1]);
    assign hs      = CHAN_W'(nb[1][0]) + CHAN_W'(nb[1][2]);
    assign ds      = CHAN_W'(nb[0][0]) + CHAN_W'(nb[0][2])
                   + CHAN_W'(nb[2][0]) + CHAN_W'(nb[2][2]);
    assign vs2     = {vs[CHAN_W-2:0], 1'b0};
    assign hs2     = {hs[CHAN_W-2:0], 1'b0};
    assign hv      = vs + hs;
    assign both_ud = c_meta_reg.up & c_meta_reg.down;
    assign both_lr = c_meta_reg.left & c_meta_reg.right;
    assign all_in  = both_ud & both_lr;

    always_comb begin
        c_result.row_end   = c_meta_reg.row_end;
        c_result.frame_end = c_meta_reg.frame_end;
        if (c_meta_reg.row_odd == c_meta_reg.col_odd) begin
            c_result.green = pass_v;
            if (!c_meta_reg.row_odd) begin
                c_result.red  = both_ud ? vs2 : '0;
                c_result.blue = both_lr ? hs2 : '0;
            end else begin
                c_result.red  = both_lr ? hs2 : '0;
                c_result.blue = both_ud ? vs2 : '0;
            end
        end else if (!c_meta_reg.row_odd) begin
            c_result.blue  = pass_v;
            c_result.green = all_in ? hv : '0;
            c_result.red   = all_in ? ds : '0;
        end else begin
            c_result.red   = pass_v;
            c_result.green = all_in ? hv : '0;
            c_result.blue  = all_in ? ds : '0;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign push      = c_emit_reg;
    assign pop       = m_tvalid & m_tready;
    assign occupancy = cnt_reg + FIFO_CNT_W'(b_emit_reg) + FIFO_CNT_W'(c_emit_reg);
    assign s_tready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
    assign cnt_next  = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= c_result;
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = M_DATA_W'({head.blue, head.green, head.red});
    assign m_tlast  = head.row_end;
    assign m_tuser  = head.frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_queue_no_overflow, (push && !pop) |-> (cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)), "result queue overflow")
    `ASSERT_CLK(a_inflight_bound, occupancy <= FIFO_CNT_W'(FIFO_DEPTH), "in-flight results exceed queue")
    `ASSERT_CLK(a_fwd_into_advance, fwd_hit_reg |-> b_adv_reg, "forward without line store update")
    `ASSERT_NEVER(a_drain_mid_frame, (pend_reg != '0) && (col_cnt_reg != '0 || row_cnt_reg != '0), "drain owed while frame open")

endmodule

FILE: rtl/bbd_ram.sv
// ---------------------------------------------------------------------------
// bbd_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module bbd_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8192,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
